// ===== sv/vlr_pkg.sv =====
// Package for the vector length/rescale pipeline: word widths and payload structs.
// Shared types and the saturation helper; no dependencies.
`default_nettype none
package vlr_pkg;

    localparam int W        = 32;          // width of every data word
    localparam int F        = 16;          // fraction bits of the Q format
    localparam int SQ_BITS  = 2 * W;       // width of a sum of squares
    localparam int REM_BITS = W + 2;       // square root partial remainder

    typedef enum logic [1:0] {
        ACT_LENGTH    = 2'd0,
        ACT_NORMALIZE = 2'd1,
        ACT_SET       = 2'd2,
        ACT_CLAMP     = 2'd3
    } action_t;

    // Action, magnitudes and signs of the input transaction.
    typedef struct packed {
        action_t        action;
        logic [W-1:0]   mx;
        logic [W-1:0]   my;
        logic [W-1:0]   mt;
        logic           nx;
        logic           ny;
        logic           nt;
    } side_t;

    // What the output stage needs after the divider.
    typedef struct packed {
        logic [W-1:0]   len;
        logic [W-1:0]   ox;
        logic [W-1:0]   oy;
        logic           scale;
        logic           err;
        logic           negx;
        logic           negy;
    } post_t;

    // Apply the sign to a magnitude quotient and saturate to signed W bits.
    function automatic logic [W-1:0] sat_signed(input logic [W-1:0] q,
                                                input logic ovf,
                                                input logic neg);
        logic [W-1:0] lim;
        logic [W-1:0] m;
        lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        m   = (ovf || (q > lim)) ? lim : q;
        return neg ? (~m + 1'b1) : m;
    endfunction

endpackage
`default_nettype wire

// ===== sv/vector2d_length_rescale.sv =====
// Vector length / normalize / rescale / clamp pipeline, signed Q16.16.
// Stages from input transaction to result: 3 front stages, 32 square root
// stages, 2 scale stages, 33 divider stages, 1 output stage.
// Throughput: one transaction per cycle; the whole pipeline advances together
// and stalls only while a result sits unaccepted at the output.
// Reset (rst_n, async, active low) clears all valid bits; payload is not reset.
`default_nettype none
module vector2d_length_rescale (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            action,
    input  wire logic [vlr_pkg::W-1:0] vec_x,
    input  wire logic [vlr_pkg::W-1:0] vec_y,
    input  wire logic [vlr_pkg::W-1:0] target_length,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [vlr_pkg::W-1:0]      out_x,
    output logic [vlr_pkg::W-1:0]      out_y,
    output logic [vlr_pkg::W-1:0]      length,
    output logic                       zero_divide
);
    import vlr_pkg::*;

    // Advance every stage whenever the output register is free or being drained.
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Stage A: magnitudes and signs.
    logic  a_valid_reg;
    side_t a_side_reg;
    side_t a_side_next;

    always_comb
    begin
        a_side_next.action = action_t'(action);
        a_side_next.nx     = vec_x[W-1];
        a_side_next.ny     = vec_y[W-1];
        a_side_next.nt     = target_length[W-1];
        a_side_next.mx     = vec_x[W-1] ? (~vec_x + 1'b1) : vec_x;
        a_side_next.my     = vec_y[W-1] ? (~vec_y + 1'b1) : vec_y;
        a_side_next.mt     = target_length[W-1] ? (~target_length + 1'b1) : target_length;
    end

    // Stage B: squares. Stage C: sum of squares (fits 2W bits).
    logic               b_valid_reg;
    side_t              b_side_reg;
    logic [SQ_BITS-1:0] b_sqx_reg;
    logic [SQ_BITS-1:0] b_sqy_reg;
    logic               c_valid_reg;
    side_t              c_side_reg;
    logic [SQ_BITS-1:0] c_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= a_side_next;
            b_side_reg <= a_side_reg;
            b_sqx_reg  <= SQ_BITS'(a_side_reg.mx) * SQ_BITS'(a_side_reg.mx);
            b_sqy_reg  <= SQ_BITS'(a_side_reg.my) * SQ_BITS'(a_side_reg.my);
            c_side_reg <= b_side_reg;
            c_sum_reg  <= b_sqx_reg + b_sqy_reg;
        end
    end

    // Square root: floor(sqrt(sum)), exact.
    logic         s_valid;
    logic [W-1:0] s_root;
    side_t        s_side;

    vlr_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .radicand  (c_sum_reg),
        .in_side   (c_side_reg),
        .out_valid (s_valid),
        .root      (s_root),
        .out_side  (s_side)
    );

    // Stage D: choose the scale factor for the action.
    logic         d_valid_reg;
    post_t        d_post_reg;
    logic [W-1:0] d_factor_reg;
    logic [W-1:0] d_mx_reg;
    logic [W-1:0] d_my_reg;
    post_t        d_post_next;
    logic [W-1:0] d_factor_next;
    logic         fneg;

    always_comb
    begin
        d_post_next.scale = 1'b0;
        d_factor_next     = '0;
        fneg              = 1'b0;
        case (s_side.action)
            ACT_NORMALIZE:
            begin
                d_post_next.scale = 1'b1;
                d_factor_next     = W'(1) << F;
            end
            ACT_SET:
            begin
                d_post_next.scale = 1'b1;
                d_factor_next     = s_side.mt;
                fneg              = s_side.nt;
            end
            ACT_CLAMP:
            begin
                // Negative limit is always exceeded.
                if (s_side.nt || (s_root > s_side.mt))
                begin
                    d_post_next.scale = 1'b1;
                    d_factor_next     = s_side.mt;
                    fneg              = s_side.nt;
                end
            end
            default:
            begin
                d_post_next.scale = 1'b0;
            end
        endcase
        d_post_next.len  = s_root;
        d_post_next.ox   = s_side.nx ? (~s_side.mx + 1'b1) : s_side.mx;
        d_post_next.oy   = s_side.ny ? (~s_side.my + 1'b1) : s_side.my;
        d_post_next.err  = d_post_next.scale && (s_root == '0);
        d_post_next.negx = s_side.nx ^ fneg;
        d_post_next.negy = s_side.ny ^ fneg;
    end

    // Stage E: numerators |c| * factor.
    logic               e_valid_reg;
    post_t              e_post_reg;
    logic [SQ_BITS-1:0] e_px_reg;
    logic [SQ_BITS-1:0] e_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= s_valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_post_reg   <= d_post_next;
            d_factor_reg <= d_factor_next;
            d_mx_reg     <= s_side.mx;
            d_my_reg     <= s_side.my;
            e_post_reg   <= d_post_reg;
            e_px_reg     <= SQ_BITS'(d_mx_reg) * SQ_BITS'(d_factor_reg);
            e_py_reg     <= SQ_BITS'(d_my_reg) * SQ_BITS'(d_factor_reg);
        end
    end

    // Divide by the length; quotient truncated, overflow flagged for saturation.
    logic         q_valid;
    logic [W-1:0] qx;
    logic [W-1:0] qy;
    logic         qovf_x;
    logic         qovf_y;
    post_t        q_post;

    vlr_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .num_x     (e_px_reg),
        .num_y     (e_py_reg),
        .den       (e_post_reg.len),
        .in_post   (e_post_reg),
        .out_valid (q_valid),
        .quot_x    (qx),
        .quot_y    (qy),
        .ovf_x     (qovf_x),
        .ovf_y     (qovf_y),
        .out_post  (q_post)
    );

    // Output stage: sign, saturate and select the result.
    logic         out_valid_reg;
    logic [W-1:0] out_x_reg;
    logic [W-1:0] out_y_reg;
    logic [W-1:0] length_reg;
    logic         zero_divide_reg;
    logic [W-1:0] out_x_next;
    logic [W-1:0] out_y_next;

    always_comb
    begin
        if (!q_post.scale)
        begin
            out_x_next = q_post.ox;
            out_y_next = q_post.oy;
        end
        else if (q_post.err)
        begin
            out_x_next = '0;
            out_y_next = '0;
        end
        else
        begin
            out_x_next = sat_signed(qx, qovf_x, q_post.negx);
            out_y_next = sat_signed(qy, qovf_y, q_post.negy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
            length_reg      <= q_post.len;
            zero_divide_reg <= q_post.err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign length      = length_reg;
    assign zero_divide = zero_divide_reg;

endmodule
`default_nettype wire

// ===== sv/vlr_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, sideband carried along.
// Depends on vlr_pkg.
`default_nettype none
module vlr_isqrt (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [vlr_pkg::SQ_BITS-1:0] radicand,
    input  wire vlr_pkg::side_t          in_side,
    output logic                         out_valid,
    output logic [vlr_pkg::W-1:0]        root,
    output vlr_pkg::side_t               out_side
);
    import vlr_pkg::*;

    logic                valid_reg [0:W-1];
    logic [SQ_BITS-1:0]  rad_reg   [0:W-1];
    logic [REM_BITS-1:0] rem_reg   [0:W-1];
    logic [W-1:0]        root_reg  [0:W-1];
    side_t               side_reg  [0:W-1];

    for (genvar k = 0; k < W; k++) begin : g_step
        logic                pv;
        logic [SQ_BITS-1:0]  prad;
        logic [REM_BITS-1:0] prem;
        logic [W-1:0]        proot;
        side_t               pside;
        logic [REM_BITS-1:0] rem_t;
        logic [REM_BITS-1:0] trial;
        logic [REM_BITS-1:0] rem_next;
        logic [W-1:0]        root_next;

        if (k == 0) begin : g_first
            assign pv    = in_valid;
            assign prad  = radicand;
            assign prem  = '0;
            assign proot = '0;
            assign pside = in_side;
        end else begin : g_rest
            assign pv    = valid_reg[k-1];
            assign prad  = rad_reg[k-1];
            assign prem  = rem_reg[k-1];
            assign proot = root_reg[k-1];
            assign pside = side_reg[k-1];
        end

        always_comb
        begin
            rem_t = {prem[REM_BITS-3:0], prad[2*(W-1-k)+1 -: 2]};
            trial = {proot, 2'b01};
            if (rem_t >= trial)
            begin
                rem_next  = rem_t - trial;
                root_next = {proot[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_t;
                root_next = {proot[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= prad;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= pside;
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign root      = root_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule
`default_nettype wire

// ===== sv/vlr_divide.sv =====
// Two-lane pipelined restoring divider with overflow detect, one quotient bit per stage.
// Depends on vlr_pkg.
`default_nettype none
module vlr_divide (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [vlr_pkg::SQ_BITS-1:0] num_x,
    input  wire logic [vlr_pkg::SQ_BITS-1:0] num_y,
    input  wire logic [vlr_pkg::W-1:0]   den,
    input  wire vlr_pkg::post_t          in_post,
    output logic                         out_valid,
    output logic [vlr_pkg::W-1:0]        quot_x,
    output logic [vlr_pkg::W-1:0]        quot_y,
    output logic                         ovf_x,
    output logic                         ovf_y,
    output vlr_pkg::post_t               out_post
);
    import vlr_pkg::*;

    logic         valid_reg [0:W];
    logic [W-1:0] den_reg   [0:W];
    post_t        post_reg  [0:W];
    logic [W-1:0] rem_reg   [0:W][0:1];
    logic [W-1:0] low_reg   [0:W][0:1];
    logic [W-1:0] q_reg     [0:W][0:1];
    logic         ovf_reg   [0:W][0:1];

    // Entry stage: flag quotients that cannot fit W bits, load the high half.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]    <= den;
            post_reg[0]   <= in_post;
            rem_reg[0][0] <= num_x[SQ_BITS-1:W];
            rem_reg[0][1] <= num_y[SQ_BITS-1:W];
            low_reg[0][0] <= num_x[W-1:0];
            low_reg[0][1] <= num_y[W-1:0];
            q_reg[0][0]   <= '0;
            q_reg[0][1]   <= '0;
            ovf_reg[0][0] <= (num_x[SQ_BITS-1:W] >= den);
            ovf_reg[0][1] <= (num_y[SQ_BITS-1:W] >= den);
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [W:0]   r2;
            logic [W-1:0] rem_next;
            logic [W-1:0] q_next;

            always_comb
            begin
                r2 = {rem_reg[k-1][l], low_reg[k-1][l][W-1]};
                if (r2 >= {1'b0, den_reg[k-1]})
                begin
                    rem_next = W'(r2 - {1'b0, den_reg[k-1]});
                    q_next   = {q_reg[k-1][l][W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = r2[W-1:0];
                    q_next   = {q_reg[k-1][l][W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k][l] <= rem_next;
                    low_reg[k][l] <= {low_reg[k-1][l][W-2:0], 1'b0};
                    q_reg[k][l]   <= q_next;
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k]  <= den_reg[k-1];
                post_reg[k] <= post_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[W];
    assign quot_x    = q_reg[W][0];
    assign quot_y    = q_reg[W][1];
    assign ovf_x     = ovf_reg[W][0];
    assign ovf_y     = ovf_reg[W][1];
    assign out_post  = post_reg[W];

endmodule
`default_nettype wire

// ===== sv/vlr_checker.sv =====
// Port-level checker for vector2d_length_rescale, bound to the top level.
// Depends on vlr_pkg.
`default_nettype none
module vlr_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [vlr_pkg::W-1:0] out_x,
    input wire logic [vlr_pkg::W-1:0] out_y,
    input wire logic [vlr_pkg::W-1:0] length,
    input wire logic                  zero_divide
);
    import vlr_pkg::*;

    // An empty output never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A stalled result stays valid.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(length))
        else $error("result changed while stalled");

    // Division by zero yields a zero vector.
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_divide |-> out_x == '0 && out_y == '0)
        else $error("zero_divide with nonzero vector");

    // Division by zero only happens for a zero length.
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_divide |-> length == '0)
        else $error("zero_divide with nonzero length");

endmodule

bind vector2d_length_rescale vlr_checker u_vlr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .length      (length),
    .zero_divide (zero_divide)
);
`default_nettype wire
